[sv/atoib_pkg.sv]
package atoib_pkg;

    localparam int BASE_LEN_W      = 5;
    localparam int SYM_W           = 64;
    localparam int DIGIT_W         = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    // reset values: decimal alphabet "0123456789"
    localparam logic [BASE_LEN_W-1:0] BASE_LENGTH_RST  = 5'd10;
    localparam logic [SYM_W-1:0]      SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [SYM_W-1:0]      SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    // classified character word passed from front to back
    typedef struct packed {
        logic                  first;
        logic                  last;
        logic                  is_ws;
        logic                  is_plus;
        logic                  is_minus;
        logic                  is_digit;
        logic [DIGIT_W-1:0]    digit;
        logic [BASE_LEN_W-1:0] base_len;
    } word_t;

    // pick symbol k out of the packed alphabet, symbol 0 in the low byte
    function automatic logic [7:0] sym_at(input logic [2*SYM_W-1:0] syms,
                                          input logic [DIGIT_W-1:0] k);
        return syms[{k, 3'b000} +: 8];
    endfunction

endpackage

[sv/atoib_front.sv]
module atoib_front #(
    parameter int MAX_SYMBOLS = atoib_pkg::MAX_SYMBOLS_DEF
) (
    input  logic [7:0]                      ch,
    input  logic                            first,
    input  logic                            last,
    input  logic [atoib_pkg::BASE_LEN_W-1:0] base_length,
    input  logic [2*atoib_pkg::SYM_W-1:0]   symbols,
    output atoib_pkg::word_t                word
);
    import atoib_pkg::*;

    logic                hit;
    logic [DIGIT_W-1:0]  digit;

    // look the character up in the alphabet, lowest position wins
    always_comb begin
        hit   = 1'b0;
        digit = '0;
        for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
            if ((BASE_LEN_W'(k) < base_length) &&
                (sym_at(symbols, DIGIT_W'(k)) == ch)) begin
                hit   = 1'b1;
                digit = DIGIT_W'(k);
            end
        end
    end

    // classify the character with the configuration present on arrival
    always_comb begin
        word.first    = first;
        word.last     = last;
        word.is_ws    = (ch inside {[CH_TAB:CH_CR], CH_SPACE});
        word.is_plus  = (ch == CH_PLUS);
        word.is_minus = (ch == CH_MINUS);
        word.is_digit = hit;
        word.digit    = digit;
        word.base_len = base_length;
    end

endmodule

[sv/atoib_queue.sv]
module atoib_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  atoib_pkg::word_t push_word,
    output logic             pop_valid,
    input  logic             pop_ready,
    output atoib_pkg::word_t pop_word
);
    import atoib_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    word_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the incoming word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

[sv/atoib_back.sv]
module atoib_back #(
    parameter int MAX_SYMBOLS = atoib_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             word_valid,
    output logic                             word_ready,
    input  atoib_pkg::word_t                 word,
    input  logic [atoib_pkg::BASE_LEN_W-1:0] base_length,
    input  logic [2*atoib_pkg::SYM_W-1:0]    symbols,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [31:0]               m_value,
    output logic                             m_base_ok
);
    import atoib_pkg::*;

    phase_t             phase_reg, phase_next, phase_cur;
    logic               negative_reg, negative_next, negative_cur;
    logic [31:0]        acc_reg, acc_next, acc_cur;
    logic [31:0]        acc_step;
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_value_reg;
    logic               m_base_ok_reg;
    logic               alphabet_ok;
    logic               do_pop;
    logic [7:0]         si, sj;

    // hold a last word while its result would overwrite a waiting one
    assign word_ready = !word.last || !m_valid_reg || m_ready;
    assign do_pop     = word_valid && word_ready;

    // a first word starts from the cleared parse state
    assign phase_cur    = word.first ? PH_SKIP : phase_reg;
    assign negative_cur = word.first ? 1'b0 : negative_reg;
    assign acc_cur      = word.first ? '0 : acc_reg;

    // one digit step: multiply by the radix and subtract the digit
    assign acc_step = 32'(acc_cur * word.base_len) - 32'(word.digit);

    // parse state machine
    always_comb begin
        phase_next    = phase_cur;
        negative_next = negative_cur;
        acc_next      = acc_cur;
        case (phase_cur)
            PH_SKIP: begin
                if (word.is_ws) begin
                    phase_next = PH_SKIP;
                end else if (word.is_plus || word.is_minus) begin
                    phase_next    = PH_SIGN;
                    negative_next = negative_cur ^ word.is_minus;
                end else if (word.is_digit) begin
                    phase_next = PH_DIGIT;
                    acc_next   = acc_step;
                end else begin
                    phase_next = PH_STOP;
                end
            end
            PH_SIGN: begin
                if (word.is_plus || word.is_minus) begin
                    negative_next = negative_cur ^ word.is_minus;
                end else if (word.is_digit) begin
                    phase_next = PH_DIGIT;
                    acc_next   = acc_step;
                end else begin
                    phase_next = PH_STOP;
                end
            end
            PH_DIGIT: begin
                if (word.is_digit) begin
                    acc_next = acc_step;
                end else begin
                    phase_next = PH_STOP;
                end
            end
            default: begin
                phase_next = PH_STOP;
            end
        endcase
    end

    // alphabet check: length, forbidden bytes and duplicates
    always_comb begin
        alphabet_ok = (base_length >= BASE_LEN_W'(2)) &&
                      (base_length <= BASE_LEN_W'(MAX_SYMBOLS));
        si = '0;
        sj = '0;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            si = sym_at(symbols, DIGIT_W'(i));
            if (BASE_LEN_W'(i) < base_length) begin
                if ((si <= CH_SPACE) || (si >= CH_DEL) ||
                    (si == CH_PLUS) || (si == CH_MINUS)) begin
                    alphabet_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    sj = sym_at(symbols, DIGIT_W'(j));
                    if ((BASE_LEN_W'(j) < base_length) && (sj == si)) begin
                        alphabet_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (do_pop && word.last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // advance parse state; a last word returns it to reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SKIP;
            negative_reg <= 1'b0;
            acc_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (do_pop) begin
                if (word.last) begin
                    phase_reg    <= PH_SKIP;
                    negative_reg <= 1'b0;
                    acc_reg      <= '0;
                end else begin
                    phase_reg    <= phase_next;
                    negative_reg <= negative_next;
                    acc_reg      <= acc_next;
                end
            end
        end
    end

    // capture the result word
    always_ff @(posedge aclk) begin
        if (do_pop && word.last) begin
            m_base_ok_reg <= alphabet_ok;
            if (!alphabet_ok) begin
                m_value_reg <= '0;
            end else if (negative_next) begin
                m_value_reg <= acc_next;
            end else begin
                m_value_reg <= 32'(32'd0 - acc_next);
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_value   = m_value_reg;
    assign m_base_ok = m_base_ok_reg;

endmodule

[sv/ascii_to_int_any_base.sv]
// Signed integer parser over a configurable digit alphabet.
// Input channel (s_*): one character word per handshake, with s_first
// marking the start of a string and s_last its final character.
// Output channel (m_*): one result word per string, given on the word
// marked last: m_value is the parsed value modulo 2^32 and m_base_ok
// tells whether the alphabet is usable (m_value is 0 when it is not).
// Configuration: cfg_wr_en writes cfg_data to register cfg_index
// (0 base_length, 1 symbols_low, 2 symbols_high); write only while idle.
// Throughput: one character per cycle while s_ready is high. The front
// classifies a character with parallel comparators against the alphabet
// and pushes it into a two-word queue; the back takes one word a cycle
// unless it holds a last word for a waiting result, and runs the
// multiply-subtract on its accumulator. Result path: the last character
// is written to the queue, then m_valid rises from the output register
// once the words still ahead of it in the queue have been taken.
// Reset: the parse state clears, the queue and output empty, and the
// registers return to the decimal alphabet "0123456789".
// Stall: a waiting result holds; characters keep flowing until the back
// reaches another last word, after which the queue fills and s_ready drops.
module ascii_to_int_any_base #(
    parameter int MAX_SYMBOLS = atoib_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_ch,
    input  logic                            s_first,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [31:0]              m_value,
    output logic                            m_base_ok,
    input  logic                            cfg_wr_en,
    input  logic [atoib_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [atoib_pkg::SYM_W-1:0]     cfg_data
);
    import atoib_pkg::*;

    logic [BASE_LEN_W-1:0] base_length_reg;
    logic [SYM_W-1:0]      symbols_low_reg;
    logic [SYM_W-1:0]      symbols_high_reg;
    logic [2*SYM_W-1:0]    symbols;
    word_t                 front_word;
    word_t                 q_word;
    logic                  q_valid, q_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_length_reg  <= BASE_LENGTH_RST;
            symbols_low_reg  <= SYMBOLS_LOW_RST;
            symbols_high_reg <= SYMBOLS_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BASE_LENGTH:  base_length_reg  <= cfg_data[BASE_LEN_W-1:0];
                CFG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_data;
                CFG_SYMBOLS_HIGH: symbols_high_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign symbols = {symbols_high_reg, symbols_low_reg};

    atoib_front #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_front (
        .ch          (s_ch),
        .first       (s_first),
        .last        (s_last),
        .base_length (base_length_reg),
        .symbols     (symbols),
        .word        (front_word)
    );

    atoib_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_word  (front_word),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_word   (q_word)
    );

    atoib_back #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .word_valid  (q_valid),
        .word_ready  (q_ready),
        .word        (q_word),
        .base_length (base_length_reg),
        .symbols     (symbols),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_base_ok   (m_base_ok)
    );

    // an unusable alphabet always reports zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_base_ok) |-> (m_value == 32'sd0))
        else $error("result with bad alphabet carries a nonzero value");

    // a last word never leaves the queue while a result is stuck
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready && q_word.last) |-> (!m_valid || m_ready))
        else $error("result overwritten while output stalled");

    // no result appears with nothing in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_valid && !m_valid) |=> !m_valid)
        else $error("result produced without a last word");

endmodule
